### src/tam_pkg.sv
// shared types, constants and codes for the annealing move block
`timescale 1ns / 1ps
package tam_pkg;

  localparam int MAX_CITIES = 256;
  localparam int IDX_W      = $clog2(MAX_CITIES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int COORD_BITS = 16;
  localparam int LEN_W      = 32;
  localparam int SQ_OP_W    = 2 * COORD_BITS + 2;
  localparam int SQ_ROOT_W  = SQ_OP_W / 2;
  localparam int SQ_REM_W   = SQ_ROOT_W + 2;
  localparam int SQ_CNT_W   = $clog2(SQ_ROOT_W);

  localparam logic [CNT_W-1:0] CITY_COUNT_RST = CNT_W'(32);
  localparam logic [CNT_W-1:0] MIN_CITIES     = CNT_W'(3);

  localparam logic [1:0] KIND_LOAD_CITY = 2'd0;
  localparam logic [1:0] KIND_LOAD_TOUR = 2'd1;
  localparam logic [1:0] KIND_PROPOSE   = 2'd2;
  localparam logic [1:0] KIND_NONE      = 2'd3;

  localparam logic [1:0] MUT_SWAP    = 2'd0;
  localparam logic [1:0] MUT_ROTATE  = 2'd1;
  localparam logic [1:0] MUT_REVERSE = 2'd2;
  localparam logic [1:0] MUT_NONE    = 2'd3;

  typedef struct packed {
    logic [1:0]            kind;
    logic [IDX_W-1:0]      city_index;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic [IDX_W-1:0]      tour_position;
    logic [1:0]            mutation;
    logic [CNT_W-1:0]      first_arg;
    logic [CNT_W-1:0]      second_arg;
    logic [15:0]           beta;
    logic [31:0]           accept_limit;
  } in_t;

  typedef struct packed {
    logic             accepted;
    logic [LEN_W-1:0] tour_length;
    logic             status;
  } out_t;

  typedef struct packed {
    logic load;
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic take_first;
    logic edge_mul;
    logic use_first;
    logic sq_start;
    logic acc_clr;
    logic acc_add;
    logic save_old;
    logic mul;
    logic decide;
    logic copy_wr;
    logic flip;
    logic res_load;
    logic cand;
  } cmd_t;

  typedef struct packed {
    logic args_ok;
    logic last;
    logic idx_full;
    logic sq_done;
    logic sq_busy;
    logic take;
  } sts_t;

endpackage

### src/tam_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module tam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/tam_isqrt.sv
// iterative integer square root, two operand bits per cycle
`timescale 1ns / 1ps
module tam_isqrt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [tam_pkg::SQ_OP_W-1:0]    op_i,
  output logic [tam_pkg::SQ_ROOT_W-1:0]  root_o,
  output logic                           done_o,
  output logic                           busy_o
);

  logic                           busy_q, done_q;
  logic [tam_pkg::SQ_CNT_W-1:0]   cnt_q;
  logic [tam_pkg::SQ_OP_W-1:0]    op_q;
  logic [tam_pkg::SQ_REM_W-1:0]   rem_q;
  logic [tam_pkg::SQ_ROOT_W-1:0]  root_q;
  logic [tam_pkg::SQ_REM_W+1:0]   rem_sh, trial;
  logic                           ge;

  assign rem_sh = {rem_q, op_q[tam_pkg::SQ_OP_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tam_pkg::SQ_CNT_W'(tam_pkg::SQ_ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q <= {op_q[tam_pkg::SQ_OP_W-3:0], 2'b00};
      if (ge) begin
        rem_q  <= tam_pkg::SQ_REM_W'(rem_sh - trial);
        root_q <= {root_q[tam_pkg::SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= tam_pkg::SQ_REM_W'(rem_sh);
        root_q <= {root_q[tam_pkg::SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;
  assign busy_o = busy_q;

endmodule

### src/tam_datapath.sv
// tables, tour walk address mapping, edge length, sum and acceptance test
`timescale 1ns / 1ps
module tam_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tam_pkg::CNT_W-1:0] cfg_data_i,
  input  tam_pkg::in_t              in_data_i,
  input  tam_pkg::cmd_t             cmd_i,
  output tam_pkg::sts_t             sts_o,
  output tam_pkg::out_t             out_data_o
);

  localparam int IW = tam_pkg::IDX_W;
  localparam int NW = tam_pkg::CNT_W;
  localparam int CW = tam_pkg::COORD_BITS;
  localparam int LW = tam_pkg::LEN_W;

  logic [NW-1:0]   count_q, n_eff;
  logic [1:0]      mut_q;
  logic [NW-1:0]   a1_q, a2_q;
  logic [15:0]     beta_q;
  logic [31:0]     limit_q;
  logic            bad_q, sel_q, accd_q;
  logic [IW-1:0]   idx_q;
  logic [LW-1:0]   acc_q, old_q, len_q;
  logic [LW+15:0]  prod_q;
  logic [2*CW-1:0] dx2_q, dy2_q;
  logic [CW-1:0]   first_x_q, first_y_q, prev_x_q, prev_y_q;
  tam_pkg::out_t   res_q;

  logic [NW-1:0]   i9, map9;
  logic [NW:0]     rot_s, rev_s;
  logic [IW-1:0]   map_idx;
  logic            args_ok;
  logic [IW:0]     tour_raddr, tour_waddr;
  logic            tour_we;
  logic [IW-1:0]   tour_wdata, tour_rdata;
  logic            coord_we;
  logic [2*CW-1:0] coord_rdata;
  logic [CW-1:0]   cur_x, cur_y, dx, dy;
  logic [tam_pkg::SQ_OP_W-1:0]   sq_op;
  logic [tam_pkg::SQ_ROOT_W-1:0] sq_root;
  logic [LW:0]     acc_sum;
  logic            sq_done, sq_busy;

  always_comb begin
    n_eff = count_q;
    if (count_q < tam_pkg::MIN_CITIES) begin
      n_eff = tam_pkg::MIN_CITIES;
    end else if (count_q > NW'(tam_pkg::MAX_CITIES)) begin
      n_eff = NW'(tam_pkg::MAX_CITIES);
    end
  end

  always_comb begin
    case (in_data_i.mutation)
      tam_pkg::MUT_SWAP:    args_ok = (in_data_i.first_arg < n_eff) &&
                                      (in_data_i.second_arg < n_eff);
      tam_pkg::MUT_ROTATE:  args_ok = in_data_i.first_arg < n_eff;
      tam_pkg::MUT_REVERSE: args_ok = (in_data_i.first_arg <= in_data_i.second_arg) &&
                                      (in_data_i.second_arg <= n_eff);
      default:              args_ok = 1'b0;
    endcase
  end

  // candidate position i reads current position map(i)
  assign i9    = {1'b0, idx_q};
  assign rot_s = {1'b0, i9} + {1'b0, a1_q};
  assign rev_s = {1'b0, a1_q} + {1'b0, a2_q} - (NW+1)'(1) - {1'b0, i9};

  always_comb begin
    case (mut_q)
      tam_pkg::MUT_SWAP: begin
        if (i9 == a1_q) begin
          map9 = a2_q;
        end else if (i9 == a2_q) begin
          map9 = a1_q;
        end else begin
          map9 = i9;
        end
      end
      tam_pkg::MUT_ROTATE: begin
        if (i9 >= n_eff) begin
          map9 = i9;
        end else if (rot_s >= {1'b0, n_eff}) begin
          map9 = NW'(rot_s - {1'b0, n_eff});
        end else begin
          map9 = NW'(rot_s);
        end
      end
      tam_pkg::MUT_REVERSE: begin
        if (i9 >= a1_q && i9 < a2_q) begin
          map9 = NW'(rev_s);
        end else begin
          map9 = i9;
        end
      end
      default: map9 = i9;
    endcase
  end

  assign map_idx = map9[IW-1:0];

  assign tour_raddr = {sel_q, (cmd_i.cand ? map_idx : idx_q)};
  assign tour_we    = (cmd_i.load && in_data_i.kind == tam_pkg::KIND_LOAD_TOUR) ||
                      cmd_i.copy_wr;
  assign tour_waddr = cmd_i.copy_wr ? {~sel_q, idx_q} : {sel_q, in_data_i.tour_position};
  assign tour_wdata = cmd_i.copy_wr ? tour_rdata : in_data_i.city_index;
  assign coord_we   = cmd_i.load && in_data_i.kind == tam_pkg::KIND_LOAD_CITY;

  tam_ram #(
    .WIDTH (IW),
    .DEPTH (2 * tam_pkg::MAX_CITIES)
  ) u_tour_ram (
    .clk_i   (clk_i),
    .we_i    (tour_we),
    .waddr_i (tour_waddr),
    .wdata_i (tour_wdata),
    .raddr_i (tour_raddr),
    .rdata_o (tour_rdata)
  );

  tam_ram #(
    .WIDTH (2 * CW),
    .DEPTH (tam_pkg::MAX_CITIES)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (coord_we),
    .waddr_i (in_data_i.city_index),
    .wdata_i ({in_data_i.coord_x, in_data_i.coord_y}),
    .raddr_i (tour_rdata),
    .rdata_o (coord_rdata)
  );

  assign cur_x = cmd_i.use_first ? first_x_q : coord_rdata[2*CW-1:CW];
  assign cur_y = cmd_i.use_first ? first_y_q : coord_rdata[CW-1:0];
  assign dx    = (cur_x > prev_x_q) ? cur_x - prev_x_q : prev_x_q - cur_x;
  assign dy    = (cur_y > prev_y_q) ? cur_y - prev_y_q : prev_y_q - cur_y;
  assign sq_op = {2'b00, dx2_q} + {2'b00, dy2_q};

  tam_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sq_start),
    .op_i    (sq_op),
    .root_o  (sq_root),
    .done_o  (sq_done),
    .busy_o  (sq_busy)
  );

  assign acc_sum = {1'b0, acc_q} + (LW+1)'(sq_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= tam_pkg::CITY_COUNT_RST;
      sel_q   <= 1'b0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_data_i;
      end
      if (cmd_i.flip) begin
        sel_q <= ~sel_q;
      end
      if (cmd_i.decide) begin
        len_q <= sts_o.take ? acc_q : old_q;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mut_q   <= in_data_i.mutation;
      a1_q    <= in_data_i.first_arg;
      a2_q    <= in_data_i.second_arg;
      beta_q  <= in_data_i.beta;
      limit_q <= in_data_i.accept_limit;
      bad_q   <= ~args_ok;
    end
    if (cmd_i.take_first) begin
      first_x_q <= coord_rdata[2*CW-1:CW];
      first_y_q <= coord_rdata[CW-1:0];
      prev_x_q  <= coord_rdata[2*CW-1:CW];
      prev_y_q  <= coord_rdata[CW-1:0];
    end
    if (cmd_i.edge_mul) begin
      dx2_q    <= dx * dx;
      dy2_q    <= dy * dy;
      prev_x_q <= cur_x;
      prev_y_q <= cur_y;
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_sum[LW] ? '1 : acc_sum[LW-1:0];
    end
    if (cmd_i.save_old) begin
      old_q <= acc_q;
    end
    if (cmd_i.mul) begin
      prod_q <= beta_q * (acc_q - old_q);
    end
    if (cmd_i.decide) begin
      accd_q <= sts_o.take;
    end
    if (cmd_i.res_load) begin
      res_q.accepted    <= bad_q ? 1'b0 : accd_q;
      res_q.tour_length <= len_q;
      res_q.status      <= bad_q;
    end
  end

  assign sts_o.args_ok  = args_ok;
  assign sts_o.last     = i9 == (n_eff - 1'b1);
  assign sts_o.idx_full = &idx_q;
  assign sts_o.sq_done  = sq_done;
  assign sts_o.sq_busy  = sq_busy;
  assign sts_o.take     = (acc_q <= old_q) || (prod_q <= (LW+16)'(limit_q));
  assign out_data_o     = res_q;

endmodule

### src/tam_ctrl.sv
// sequencer for loads, the two tour walks, acceptance and the tour copy
`timescale 1ns / 1ps
module tam_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_kind_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  tam_pkg::sts_t sts_i,
  output tam_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TOUR, ST_CITY, ST_GOT, ST_SQS, ST_SQW, ST_WEND,
    ST_MUL, ST_DEC, ST_CPR, ST_CPW, ST_DONE
  } state_e;

  state_e state_q;
  logic   first_q, closing_q, cand_q, out_valid_q;
  logic   propose;

  assign propose = in_valid_i && in_kind_i == tam_pkg::KIND_PROPOSE;

  always_comb begin
    cmd_o           = '0;
    cmd_o.cand      = cand_q;
    cmd_o.use_first = closing_q;
    case (state_q)
      ST_IDLE: begin
        if (propose) begin
          cmd_o.latch   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          cmd_o.acc_clr = 1'b1;
        end else if (in_valid_i) begin
          cmd_o.load = 1'b1;
        end
      end
      ST_GOT: begin
        if (first_q) begin
          cmd_o.take_first = 1'b1;
          cmd_o.idx_inc    = 1'b1;
        end else begin
          cmd_o.edge_mul = 1'b1;
        end
      end
      ST_SQS: cmd_o.sq_start = 1'b1;
      ST_SQW: begin
        if (sts_i.sq_done) begin
          cmd_o.acc_add = 1'b1;
          cmd_o.idx_inc = !closing_q && !sts_i.last;
        end
      end
      ST_WEND: begin
        if (!cand_q) begin
          cmd_o.save_old = 1'b1;
          cmd_o.acc_clr  = 1'b1;
          cmd_o.idx_clr  = 1'b1;
        end
      end
      ST_MUL: cmd_o.mul = 1'b1;
      ST_DEC: begin
        cmd_o.decide  = 1'b1;
        cmd_o.idx_clr = sts_i.take;
      end
      ST_CPW: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.flip    = sts_i.idx_full;
        cmd_o.idx_inc = !sts_i.idx_full;
      end
      ST_DONE: cmd_o.res_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      first_q     <= 1'b0;
      closing_q   <= 1'b0;
      cand_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (propose) begin
            first_q   <= 1'b1;
            closing_q <= 1'b0;
            cand_q    <= 1'b0;
            state_q   <= sts_i.args_ok ? ST_TOUR : ST_DONE;
          end
        end
        ST_TOUR: state_q <= ST_CITY;
        ST_CITY: state_q <= ST_GOT;
        ST_GOT: begin
          first_q <= 1'b0;
          state_q <= first_q ? ST_TOUR : ST_SQS;
        end
        ST_SQS: state_q <= ST_SQW;
        ST_SQW: begin
          if (sts_i.sq_done) begin
            if (closing_q) begin
              state_q <= ST_WEND;
            end else if (sts_i.last) begin
              closing_q <= 1'b1;
              state_q   <= ST_GOT;
            end else begin
              state_q <= ST_TOUR;
            end
          end
        end
        ST_WEND: begin
          if (!cand_q) begin
            cand_q    <= 1'b1;
            first_q   <= 1'b1;
            closing_q <= 1'b0;
            state_q   <= ST_TOUR;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_DEC;
        ST_DEC: state_q <= sts_i.take ? ST_CPR : ST_DONE;
        ST_CPR: state_q <= ST_CPW;
        ST_CPW: state_q <= sts_i.idx_full ? ST_DONE : ST_CPR;
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

### src/tsp_annealing_move.sv
// Loads write their table entry from the transfer. A proposal walks the current then the candidate
// tour, per city: tour read, coordinate read, squares, sqrt start, 17 sqrt steps, sqrt done.
// The result follows the walks if rejected; if accepted, the candidate is first copied into the
// tour bank; bad arguments skip the walks. One item at a time, input ready again once the result
// is valid; a result not yet taken holds the next proposal.
// Reset: control idle, city_count 32, stored length zero, tables undefined until loaded.
`timescale 1ns / 1ps
module tsp_annealing_move (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tam_pkg::CNT_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  tam_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output tam_pkg::out_t             out_data_o
);

  tam_pkg::cmd_t cmd;
  tam_pkg::sts_t sts;

  tam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_kind_i   (in_data_i.kind),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tam_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  a_bad_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status) |-> !out_data_o.accepted)
    else $error("rejected arguments reported as accepted");

  a_idle_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !sts.sq_busy)
    else $error("square root busy while idle");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised without a proposal in flight");

endmodule

### bench/testbench.sv
// self-checking testbench for the annealing move block: directed table, full table fill, then random items
`timescale 1ns / 1ps
module testbench;

  typedef logic [tam_pkg::IDX_W-1:0] tour_t [tam_pkg::MAX_CITIES];

  typedef struct {
    tam_pkg::in_t  item;
    bit            typed;
    tam_pkg::out_t res;
  } row_t;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int SETTLE       = 20;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [tam_pkg::CNT_W-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  tam_pkg::in_t  in_data_i;
  tam_pkg::out_t out_data_o;

  logic [tam_pkg::COORD_BITS-1:0] city_x [tam_pkg::MAX_CITIES];
  logic [tam_pkg::COORD_BITS-1:0] city_y [tam_pkg::MAX_CITIES];
  tour_t tour_now;
  logic [tam_pkg::LEN_W-1:0] stored_len = '0;
  int unsigned cities_cfg;

  tam_pkg::out_t pending_moves[$];
  int   errors = 0;
  int   cycles = 0;
  int   send_idle, recv_idle;
  int   hold_req = 0;
  int   hold_seen = 0;
  int   hold_cnt = 0;
  bit   typed_on;
  tam_pkg::out_t typed_res;

  tsp_annealing_move u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] isqrt34(logic [33:0] v);
    logic [63:0] root, rem, trial;
    root = 0;
    rem  = 0;
    for (int i = 16; i >= 0; i--) begin
      rem   = (rem << 2) | v[2*i +: 2];
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic logic [63:0] hop_len(logic [tam_pkg::IDX_W-1:0] a,
                                          logic [tam_pkg::IDX_W-1:0] b);
    logic [tam_pkg::COORD_BITS-1:0] dx, dy;
    logic [33:0] sq;
    dx = (city_x[a] > city_x[b]) ? city_x[a] - city_x[b] : city_x[b] - city_x[a];
    dy = (city_y[a] > city_y[b]) ? city_y[a] - city_y[b] : city_y[b] - city_y[a];
    sq = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
    return isqrt34(sq);
  endfunction

  function automatic logic [tam_pkg::LEN_W-1:0] loop_len(tour_t t, int unsigned n);
    logic [63:0] sum;
    int unsigned j;
    sum = 0;
    for (int unsigned i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      sum = sum + hop_len(t[i], t[j]);
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    end
    return sum[tam_pkg::LEN_W-1:0];
  endfunction

  function automatic int unsigned live_count();
    if (cities_cfg < 3) return 3;
    if (cities_cfg > tam_pkg::MAX_CITIES) return tam_pkg::MAX_CITIES;
    return cities_cfg;
  endfunction

  // applies one transfer to the local state; returns 1 when a result is due
  function automatic bit anneal_step(tam_pkg::in_t it, output tam_pkg::out_t res);
    int unsigned n, a1, a2, lo, hi, src;
    bit ok, acc;
    tour_t cand;
    logic [tam_pkg::IDX_W-1:0] t;
    logic [tam_pkg::LEN_W-1:0] old_len, new_len;
    logic [63:0] cost;
    res = '0;
    if (it.kind == tam_pkg::KIND_LOAD_CITY) begin
      city_x[it.city_index] = it.coord_x;
      city_y[it.city_index] = it.coord_y;
      return 0;
    end
    if (it.kind == tam_pkg::KIND_LOAD_TOUR) begin
      tour_now[it.tour_position] = it.city_index;
      return 0;
    end
    if (it.kind != tam_pkg::KIND_PROPOSE) return 0;
    n  = live_count();
    a1 = 32'(it.first_arg);
    a2 = 32'(it.second_arg);
    case (it.mutation)
      tam_pkg::MUT_SWAP:    ok = a1 < n && a2 < n;
      tam_pkg::MUT_ROTATE:  ok = a1 < n;
      tam_pkg::MUT_REVERSE: ok = a1 <= a2 && a2 <= n;
      default:              ok = 0;
    endcase
    if (!ok) begin
      res.accepted    = 1'b0;
      res.tour_length = stored_len;
      res.status      = 1'b1;
      return 1;
    end
    cand = tour_now;
    if (it.mutation == tam_pkg::MUT_SWAP) begin
      t = cand[a1];
      cand[a1] = cand[a2];
      cand[a2] = t;
    end else if (it.mutation == tam_pkg::MUT_ROTATE) begin
      for (int unsigned i = 0; i < n; i++) begin
        src = i + a1;
        if (src >= n) src = src - n;
        cand[i] = tour_now[src];
      end
    end else begin
      lo = a1;
      hi = a2;
      while (lo + 1 < hi) begin
        t = cand[lo];
        cand[lo] = cand[hi-1];
        cand[hi-1] = t;
        lo++;
        hi--;
      end
    end
    old_len = loop_len(tour_now, n);
    new_len = loop_len(cand, n);
    cost = 64'(it.beta) * 64'(new_len - old_len);
    acc = (new_len <= old_len) || (cost <= 64'(it.accept_limit));
    if (acc) begin
      tour_now   = cand;
      stored_len = new_len;
    end else begin
      stored_len = old_len;
    end
    res.accepted    = acc;
    res.tour_length = stored_len;
    res.status      = 1'b0;
    return 1;
  endfunction

  always @(posedge clk_i) begin
    tam_pkg::out_t r;
    if (in_valid_i && in_ready_o) begin
      if (anneal_step(in_data_i, r)) begin
        pending_moves.insert(pending_moves.size(), typed_on ? typed_res : r);
      end
    end
    if (out_valid_o && out_ready_i) begin
      if (pending_moves.size() == 0) begin
        $error("unexpected result transfer: tour_length %0h", out_data_o.tour_length);
        errors++;
      end else begin
        r = pending_moves.pop_front();
        if (out_data_o.accepted !== r.accepted) begin
          $error("accepted: expected %0b, got %0b", r.accepted, out_data_o.accepted);
          errors++;
        end
        if (out_data_o.tour_length !== r.tour_length) begin
          $error("tour_length: expected %0h, got %0h", r.tour_length, out_data_o.tour_length);
          errors++;
        end
        if (out_data_o.status !== r.status) begin
          $error("status: expected %0b, got %0b", r.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver side: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_cnt  = HOLD_CYCLES;
      hold_seen = hold_req;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send(tam_pkg::in_t it);
    int gap;
    gap = ($urandom_range(99) < send_idle) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_moves.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_count(logic [tam_pkg::CNT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cities_cfg = 32'(v);
  endtask

  function automatic tam_pkg::in_t blank();
    tam_pkg::in_t it;
    it = '0;
    return it;
  endfunction

  function automatic tam_pkg::in_t city_item(int c, int x, int y);
    tam_pkg::in_t it;
    it = blank();
    it.kind       = tam_pkg::KIND_LOAD_CITY;
    it.city_index = tam_pkg::IDX_W'(c);
    it.coord_x    = tam_pkg::COORD_BITS'(x);
    it.coord_y    = tam_pkg::COORD_BITS'(y);
    return it;
  endfunction

  function automatic tam_pkg::in_t tour_item(int p, int c);
    tam_pkg::in_t it;
    it = blank();
    it.kind          = tam_pkg::KIND_LOAD_TOUR;
    it.tour_position = tam_pkg::IDX_W'(p);
    it.city_index    = tam_pkg::IDX_W'(c);
    return it;
  endfunction

  function automatic tam_pkg::in_t move_item(logic [1:0] m, int a1, int a2, int b,
                                             logic [31:0] lim);
    tam_pkg::in_t it;
    it = blank();
    it.kind         = tam_pkg::KIND_PROPOSE;
    it.mutation     = m;
    it.first_arg    = tam_pkg::CNT_W'(a1);
    it.second_arg   = tam_pkg::CNT_W'(a2);
    it.beta         = 16'(b);
    it.accept_limit = lim;
    return it;
  endfunction

  function automatic logic [15:0] rand16();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic tam_pkg::in_t random_item();
    tam_pkg::in_t it;
    int unsigned n, r, a1, a2;
    logic [1:0] m;
    logic [31:0] lim;
    n = live_count();
    r = $urandom_range(99);
    it = blank();
    it.coord_x = tam_pkg::COORD_BITS'($urandom);
    it.coord_y = tam_pkg::COORD_BITS'($urandom);
    it.city_index = tam_pkg::IDX_W'($urandom);
    it.tour_position = tam_pkg::IDX_W'($urandom);
    if (r < 12) return city_item($urandom_range(255), rand16(), rand16());
    if (r < 24) return tour_item($urandom_range(n - 1), $urandom_range(255));
    if (r < 28) begin
      it.kind = tam_pkg::KIND_NONE;
      return it;
    end
    m = 2'($urandom_range(2));
    a1 = $urandom_range(n - 1);
    a2 = $urandom_range(n - 1);
    if (m == tam_pkg::MUT_REVERSE) begin
      a2 = $urandom_range(n);
      a1 = $urandom_range(a2);
    end
    if ($urandom_range(99) < 15) begin
      a1 = $urandom_range(256);
      a2 = $urandom_range(256);
      if ($urandom_range(3) == 0) m = tam_pkg::MUT_NONE;
    end
    case ($urandom_range(4))
      0: lim = 32'h0;
      1: lim = 32'hFFFF_FFFF;
      2: lim = $urandom >> $urandom_range(31);
      default: lim = $urandom;
    endcase
    it = move_item(m, a1, a2, rand16(), lim);
    it.coord_x = tam_pkg::COORD_BITS'($urandom);
    it.coord_y = tam_pkg::COORD_BITS'($urandom);
    it.city_index = tam_pkg::IDX_W'($urandom);
    it.tour_position = tam_pkg::IDX_W'($urandom);
    return it;
  endfunction

  row_t directed[$];

  task automatic add_row(tam_pkg::in_t it, bit typed = 0, tam_pkg::out_t r = '0);
    row_t row;
    row.item  = it;
    row.typed = typed;
    row.res   = r;
    directed.insert(directed.size(), row);
  endtask

  initial begin
    int counts[9];
    int idle_tx[3], idle_rx[3];
    int n_items;
    tam_pkg::out_t bad;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    typed_on = 0;
    typed_res = '0;
    send_idle = 0;
    recv_idle = 0;
    cities_cfg = 32'(tam_pkg::CITY_COUNT_RST);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    bad = '0;
    bad.status = 1'b1;
    // reset length is zero, so bad arguments return zero
    add_row(move_item(tam_pkg::MUT_SWAP, 32, 0, 1, 0), 1, bad);
    add_row(move_item(tam_pkg::MUT_ROTATE, 256, 0, 1, 0), 1, bad);
    add_row(move_item(tam_pkg::MUT_REVERSE, 5, 4, 1, 0), 1, bad);
    add_row(move_item(tam_pkg::MUT_REVERSE, 0, 33, 1, 0), 1, bad);
    add_row(move_item(tam_pkg::MUT_NONE, 0, 0, 1, 0), 1, bad);
    add_row(city_item(0, 16'h0000, 16'h0000));
    add_row(city_item(1, 16'hFFFF, 16'hFFFF));
    add_row(city_item(2, 16'hFFFF, 16'h0000));
    add_row(city_item(255, 16'h0100, 16'h8000));
    add_row(tour_item(0, 0));
    add_row(tour_item(1, 1));
    add_row(tour_item(2, 2));
    add_row(tour_item(255, 255));
    add_row(blank());
    add_row(move_item(tam_pkg::MUT_SWAP, 0, 2, 16'hFFFF, 32'h0));
    add_row(move_item(tam_pkg::MUT_ROTATE, 2, 0, 16'hFFFF, 32'hFFFF_FFFF));
    add_row(move_item(tam_pkg::MUT_REVERSE, 0, 3, 16'h0000, 32'h0));
    add_row(move_item(tam_pkg::MUT_REVERSE, 1, 1, 16'h0100, 32'h0));
    add_row(move_item(tam_pkg::MUT_SWAP, 1, 1, 16'h0100, 32'h0));
    add_row(move_item(tam_pkg::MUT_SWAP, 3, 0, 16'h0100, 32'h0));

    write_count(tam_pkg::CNT_W'(3));
    foreach (directed[i]) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      typed_on  = directed[i].typed;
      typed_res = directed[i].res;
      send(directed[i].item);
    end
    drain();
    typed_on = 0;

    // fill every city entry and every position of the current tour bank so no proposal reads an unwritten one
    for (int c = 0; c < tam_pkg::MAX_CITIES; c++) send(city_item(c, $urandom, $urandom));
    for (int p = 0; p < tam_pkg::MAX_CITIES; p++) send(tour_item(p, $urandom_range(255)));
    drain();

    counts = '{3, 8, 256, 0, 5, 511, 12, 2, 6};
    idle_tx = '{10, 52, 0};
    idle_rx = '{52, 10, 0};
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = idle_tx[mode];
      recv_idle = idle_rx[mode];
      foreach (counts[k]) begin
        write_count(tam_pkg::CNT_W'(counts[k]));
        n_items = (live_count() == tam_pkg::MAX_CITIES) ? 2 : 5;
        if (mode == 0 && k == 0) hold_req++;
        repeat (n_items) send(random_item());
        drain();
      end
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
src/tam_pkg.sv
src/tam_ram.sv
src/tam_isqrt.sv
src/tam_datapath.sv
src/tam_ctrl.sv
src/tsp_annealing_move.sv
bench/testbench.sv
